@@ hdl/keyed_sum_aggregation_table_defines.svh @@
// assertion macros for the keyed sum aggregation table checker
// no dependencies
`ifndef KEYED_SUM_AGGREGATION_TABLE_DEFINES_SVH
`define KEYED_SUM_AGGREGATION_TABLE_DEFINES_SVH

// same-cycle implication, idle while in reset
`define KSAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ksat check failed");

// next-cycle implication, idle while in reset
`define KSAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ksat check failed");

// next-cycle implication that also holds through reset
`define KSAT_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ksat check failed");

`endif

@@ hdl/ksat_pkg.sv @@
// shared types and constants of the keyed sum aggregation table
// no dependencies
`default_nettype none
package ksat_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ID_W        = 24;
  localparam int QTY_W       = 16;
  localparam int AMT_W       = 24;
  localparam int TOT_W       = 32;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_DUMP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN_DUMP,
    ST_DRAIN_CLR,
    ST_DUMP
  } state_t;

  // add request walking down the chain
  typedef struct packed {
    logic             valid;
    logic             done;
    logic [ID_W-1:0]  id;
    logic [QTY_W-1:0] qty;
    logic [AMT_W-1:0] amt;
  } tok_t;

  // contents of one slot
  typedef struct packed {
    logic             used;
    logic [ID_W-1:0]  key;
    logic [TOT_W-1:0] qty;
    logic [TOT_W-1:0] amt;
  } slot_t;

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] total,
                                               input logic [TOT_W-1:0] inc);
    logic [TOT_W:0] sum;
    sum = {1'b0, total} + {1'b0, inc};
    return sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/ksat_cell.sv @@
// one slot of the table: key compare, claim and saturating totals
// depends on ksat_pkg
`default_nettype none
module ksat_cell (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            clr,
  input  ksat_pkg::tok_t tok_in,
  output ksat_pkg::tok_t tok_out,
  output ksat_pkg::slot_t slot
);
  import ksat_pkg::*;

  logic             used_r, used_nxt;
  logic [ID_W-1:0]  key_r, key_nxt;
  logic [TOT_W-1:0] qty_r, qty_nxt;
  logic [TOT_W-1:0] amt_r, amt_nxt;
  logic             vld_r;
  tok_t             tok_r, tok_nxt;
  logic             hit, claim;

  always_comb begin
    hit      = tok_in.valid && !tok_in.done && used_r && (key_r == tok_in.id);
    claim    = tok_in.valid && !tok_in.done && !used_r;
    used_nxt = used_r;
    key_nxt  = key_r;
    qty_nxt  = qty_r;
    amt_nxt  = amt_r;
    if (clr) begin
      used_nxt = 1'b0;
    end else if (claim) begin
      used_nxt = 1'b1;
      key_nxt  = tok_in.id;
      qty_nxt  = TOT_W'(tok_in.qty);
      amt_nxt  = TOT_W'(tok_in.amt);
    end else if (hit) begin
      qty_nxt = sat_add(qty_r, TOT_W'(tok_in.qty));
      amt_nxt = sat_add(amt_r, TOT_W'(tok_in.amt));
    end
    tok_nxt      = tok_in;
    tok_nxt.done = tok_in.done | hit | claim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      vld_r  <= tok_in.valid;
    end
    key_r <= key_nxt;
    qty_r <= qty_nxt;
    amt_r <= amt_nxt;
    tok_r <= tok_nxt;
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = vld_r;
    slot.used     = used_r;
    slot.key      = key_r;
    slot.qty      = qty_r;
    slot.amt      = amt_r;
  end

endmodule
`default_nettype wire

@@ hdl/keyed_sum_aggregation_table.sv @@
// Keyed sum aggregation table, top level.
// Depends on ksat_pkg and ksat_cell.
//
// Input stream: in_tuser carries the action (add, dump, clear), in_tdata the
// record. Add requests are taken one per cycle, back to back, while no dump
// or clear is in progress; each walks the row of TABLE_DEPTH cells, one cell
// per cycle. A record matches the slot holding its id or claims the first
// free cell it meets; one that falls off the end of the row sets the sticky
// overflow flag.
// A dump first waits until no add is still in the row, then sends one
// result per cycle while the receiver is ready, slot order, last marked by
// out_tlast; an empty table gives one result with the empty flag. The read
// side is a TABLE_DEPTH to one select over the cells. No new request is
// taken until the dump has handed all results to the output register.
// A clear waits for the row to drain, then empties the slots and overflow flag.
// The output register lets the input side keep accepting while a result
// waits; a stalled receiver holds the result and stops the dump walk.
// Reset empties all slots and clears the overflow flag.
`default_nettype none
module keyed_sum_aggregation_table (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // item_id[23:0], quantity[39:24], amount[63:40]
  input  wire  [63:0] in_tdata,
  // action[1:0]
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // out_id[23:0], total_quantity[55:24], total_amount[87:56]
  output logic [87:0] out_tdata,
  // empty_res[0], overflowed[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  import ksat_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             drop_r, drop_nxt;
  logic             ovld_r, ovld_nxt;
  logic [87:0]      odata_r, odata_nxt;
  logic [1:0]       ouser_r, ouser_nxt;
  logic             olast_r, olast_nxt;

  tok_t             tok [TABLE_DEPTH+1];
  slot_t            slots [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] busy_vec;
  logic [TABLE_DEPTH-1:0] next_used;
  logic             busy, accept, clr_all, out_free, load_out;
  slot_t            cur;
  logic             cur_last;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !ovld_r || out_tready;

  always_comb begin
    tok[0].valid = accept && (in_tuser == ACT_ADD);
    tok[0].done  = 1'b0;
    tok[0].id    = in_tdata[23:0];
    tok[0].qty   = in_tdata[39:24];
    tok[0].amt   = in_tdata[63:40];
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ksat_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (clr_all),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .slot    (slots[i])
    );
    assign busy_vec[i] = tok[i+1].valid;
    if (i < TABLE_DEPTH - 1) begin : g_nu
      assign next_used[i] = slots[i+1].used;
    end else begin : g_nu_end
      assign next_used[i] = 1'b0;
    end
  end

  assign busy     = |busy_vec;
  assign cur      = slots[idx_r];
  assign cur_last = (idx_r == IDX_W'(TABLE_DEPTH - 1)) || !next_used[idx_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_tuser)
            ACT_DUMP:  state_nxt = ST_DRAIN_DUMP;
            ACT_CLEAR: state_nxt = ST_DRAIN_CLR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DRAIN_DUMP: if (!busy) state_nxt = ST_DUMP;
      ST_DRAIN_CLR:  if (!busy) state_nxt = ST_IDLE;
      ST_DUMP: begin
        if (out_free && (!cur.used || cur_last)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    clr_all   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:       in_tready = 1'b1;
      ST_DRAIN_DUMP: ;
      ST_DRAIN_CLR:  clr_all = !busy;
      ST_DUMP:       load_out = out_free;
      default:       ;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    drop_nxt  = drop_r;
    ovld_nxt  = ovld_r;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;
    olast_nxt = olast_r;
    if (state_r == ST_DRAIN_DUMP) idx_nxt = '0;
    if (tok[TABLE_DEPTH].valid && !tok[TABLE_DEPTH].done) drop_nxt = 1'b1;
    if (clr_all) drop_nxt = 1'b0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    if (load_out) begin
      ovld_nxt = 1'b1;
      if (!cur.used) begin
        odata_nxt = '0;
        ouser_nxt = {drop_r, 1'b1};
        olast_nxt = 1'b1;
      end else begin
        odata_nxt = {cur.amt, cur.qty, cur.key};
        ouser_nxt = {drop_r, 1'b0};
        olast_nxt = cur_last;
        idx_nxt   = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drop_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
      ovld_r  <= ovld_nxt;
    end
    idx_r   <= idx_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

@@ hdl/ksat_checker.sv @@
// port-level checks of the keyed sum aggregation table, bound to the top level
// depends on keyed_sum_aggregation_table_defines.svh
`default_nettype none
`include "keyed_sum_aggregation_table_defines.svh"
module ksat_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [87:0] out_tdata,
  input wire [1:0]  out_tuser,
  input wire        out_tlast
);

  logic        out_stall;
  logic [90:0] out_word;

  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tlast, out_tuser, out_tdata};

  `KSAT_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word))
  `KSAT_ASSERT_NOW(a_empty_last, out_tvalid && out_tuser[0], out_tlast)
  `KSAT_ASSERT_NOW(a_empty_zero, out_tvalid && out_tuser[0], out_tdata == 88'd0)
  `KSAT_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid && in_tready)

endmodule

bind keyed_sum_aggregation_table ksat_checker u_ksat_checker (.*);
`default_nettype wire
